// ----- hdl/mmt_pkg.sv -----
`timescale 1ns / 1ps
package mmt_pkg;

	localparam int unsigned VAL_W  = 16;
	localparam int unsigned PROD_W = 32;
	localparam int unsigned SUM_W  = 40;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned CNT_W  = 4;

	localparam logic [1:0] OP_LOAD_A  = 2'd0;
	localparam logic [1:0] OP_LOAD_B  = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	localparam logic [2:0] REG_A_ROWS  = 3'd0;
	localparam logic [2:0] REG_A_COLS  = 3'd1;
	localparam logic [2:0] REG_B_ROWS  = 3'd2;
	localparam logic [2:0] REG_B_COLS  = 3'd3;
	localparam logic [2:0] REG_TRANS_B = 3'd4;

	typedef struct packed {
		logic                    vld;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic                    last;
		logic signed [SUM_W-1:0] sum;
	} mmt_token_t;

endpackage

// ----- hdl/mmt_cell.sv -----
`timescale 1ns / 1ps
module mmt_cell import mmt_pkg::*; #(
	parameter int unsigned IDX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  mmt_token_t               tok_in,
	input  logic                     prod_vld,
	input  logic [IDX_W-1:0]         prod_k,
	input  logic signed [PROD_W-1:0] prod,
	output mmt_token_t               tok_out
);

	logic                    add;
	logic signed [SUM_W-1:0] sum_nxt;
	mmt_token_t              tok_nxt;
	logic                    vld_q;
	mmt_token_t              pay_q;

	// term k of an element lands here exactly when its token does
	assign add     = prod_vld && tok_in.vld && (32'(prod_k) == IDX);
	assign sum_nxt = add ? tok_in.sum + SUM_W'(prod) : tok_in.sum;

	always_comb begin
		tok_nxt     = tok_in;
		tok_nxt.sum = sum_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q <= tok_nxt;
		end
	end

	always_comb begin
		tok_out     = pay_q;
		tok_out.vld = vld_q;
	end

endmodule

// ----- hdl/matrix_multiply_opt_transpose_core.sv -----
`timescale 1ns / 1ps
// a load is written into its store at the edge that accepts it; the terms of a compute
// pass the read stage, the multiply stage, the accumulate cells and the output register;
// one multiply-accumulate per cycle while the output does not stall; the next request
// after a compute is taken only once its last result has been accepted
// the sum of each element rides down a chain of MAX_DIM accumulate cells
// reset: arst_n asynchronous active low clears control and config; matrix stores are not cleared
module matrix_multiply_opt_transpose_core import mmt_pkg::*; #(
	parameter int unsigned MAX_DIM = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // opcode, row_index, col_index, element_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_row, out_col, out_value
	output logic        m_tlast,   // last_result
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned LIM   = (MAX_DIM < 8) ? MAX_DIM : 8;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

	state_t state_q;
	logic [CNT_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic             trans_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic [CNT_W-1:0] nr, nk, nc;
	logic             en, acc_in, acc_out;

	logic [1:0]              in_op;
	logic [IDX_W-1:0]        in_row, in_col;
	logic [VAL_W-1:0]        in_val;

	logic signed [VAL_W-1:0] mem_a [DEPTH];
	logic signed [VAL_W-1:0] mem_b [DEPTH];
	logic [AW-1:0]           wr_addr, rd_addr_a, rd_addr_b;
	logic                    wr_ok;

	logic                    vld_s1, vld_s2;
	logic [IDX_W-1:0]        i_s1, j_s1, k_s1, i_s2, j_s2, k_s2;
	logic                    lst_s1, lst_s2;
	logic signed [VAL_W-1:0] a_s1, b_s1;
	logic signed [PROD_W-1:0] prod_s2;

	mmt_token_t              chain [MAX_DIM+1];
	logic                    out_vld_q;
	logic [IDX_W-1:0]        out_row_q, out_col_q;
	logic signed [SUM_W-1:0] out_val_q;
	logic                    out_last_q;

	function automatic logic [CNT_W-1:0] clamp(input logic [CNT_W-1:0] c);
		if (c == '0) return CNT_W'(1);
		if (c > CNT_W'(LIM)) return CNT_W'(LIM);
		return c;
	endfunction

	assign in_op  = s_tdata[1:0];
	assign in_row = s_tdata[4:2];
	assign in_col = s_tdata[7:5];
	assign in_val = s_tdata[23:8];

	assign nr = clamp(a_rows_q);
	assign nk = clamp(a_cols_q);
	assign nc = trans_q ? clamp(b_rows_q) : clamp(b_cols_q);

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign acc_in    = s_tvalid && s_tready;
	assign acc_out   = m_tvalid && m_tready;
	assign en        = !out_vld_q || m_tready;

	assign wr_ok     = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
	assign wr_addr   = AW'(32'(in_row) * MAX_DIM + 32'(in_col));
	assign rd_addr_a = AW'(32'(i_q) * MAX_DIM + 32'(k_q));
	assign rd_addr_b = trans_q ? AW'(32'(j_q) * MAX_DIM + 32'(k_q))
	                           : AW'(32'(k_q) * MAX_DIM + 32'(j_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= CNT_W'(8);
			a_cols_q <= CNT_W'(8);
			b_rows_q <= CNT_W'(8);
			b_cols_q <= CNT_W'(8);
			trans_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_A_ROWS:  a_rows_q <= cfg_data;
				REG_A_COLS:  a_cols_q <= cfg_data;
				REG_B_ROWS:  b_rows_q <= cfg_data;
				REG_B_COLS:  b_cols_q <= cfg_data;
				REG_TRANS_B: trans_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in && in_op == OP_COMPUTE) begin
						state_q <= ST_RUN;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
					end
				end
				ST_RUN: begin
					if (en) begin
						if ({1'b0, k_q} == nk - CNT_W'(1)) begin
							k_q <= '0;
							if ({1'b0, j_q} == nc - CNT_W'(1)) begin
								j_q <= '0;
								if ({1'b0, i_q} == nr - CNT_W'(1)) begin
									state_q <= ST_DRAIN;
								end else begin
									i_q <= i_q + IDX_W'(1);
								end
							end else begin
								j_q <= j_q + IDX_W'(1);
							end
						end else begin
							k_q <= k_q + IDX_W'(1);
						end
					end
				end
				ST_DRAIN: begin
					if (acc_out && m_tlast) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && wr_ok && in_op == OP_LOAD_A) begin
			mem_a[wr_addr] <= in_val;
		end
		if (acc_in && wr_ok && in_op == OP_LOAD_B) begin
			mem_b[wr_addr] <= in_val;
		end
		if (en) begin
			a_s1 <= mem_a[rd_addr_a];
			b_s1 <= mem_b[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= (state_q == ST_RUN);
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			i_s1    <= i_q;
			j_s1    <= j_q;
			k_s1    <= k_q;
			lst_s1  <= ({1'b0, i_q} == nr - CNT_W'(1)) && ({1'b0, j_q} == nc - CNT_W'(1));
			i_s2    <= i_s1;
			j_s2    <= j_s1;
			k_s2    <= k_s1;
			lst_s2  <= lst_s1;
			prod_s2 <= PROD_W'(a_s1) * PROD_W'(b_s1);
		end
	end

	always_comb begin
		chain[0].vld  = vld_s2 && (k_s2 == '0);
		chain[0].row  = i_s2;
		chain[0].col  = j_s2;
		chain[0].last = lst_s2;
		chain[0].sum  = '0;
	end

	for (genvar n = 0; n < MAX_DIM; n++) begin : g_cell
		mmt_cell #(.IDX(n)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.tok_in  (chain[n]),
			.prod_vld(vld_s2),
			.prod_k  (k_s2),
			.prod    (prod_s2),
			.tok_out (chain[n+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= chain[MAX_DIM].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_row_q  <= chain[MAX_DIM].row;
			out_col_q  <= chain[MAX_DIM].col;
			out_val_q  <= chain[MAX_DIM].sum;
			out_last_q <= chain[MAX_DIM].last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_val_q, out_col_q, out_row_q};
	assign m_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("result pending while idle");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("block busy after final result");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 || vld_s2) |-> !s_tready)
		else $error("request taken while terms in flight");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import mmt_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam logic [1:0] OP_NONE    = 2'd3;
	localparam int DIM       = 8;
	localparam int IDLE_MAX  = 4000;
	localparam int SETTLE    = 24;

	typedef struct {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [SUM_W-1:0] value;
		logic                    last;
	} product_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [3:0]  cfg_data;

	matrix_multiply_opt_transpose_core #(.MAX_DIM(DIM)) dut (.*);

	// predictor state
	logic signed [VAL_W-1:0] mat_a [DIM*DIM];
	logic signed [VAL_W-1:0] mat_b [DIM*DIM];
	logic [CNT_W-1:0] a_rows, a_cols, b_rows, b_cols;
	logic             trans_b;
	product_t         pending_products[$];

	int errors, loads_sent, computes_sent, products_seen, idle_cycles;
	int hold_cycles, rx_stall;
	bit quiet;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		if (errors <= 20)
			$display("mismatch %s: got %0h expected %0h", what, got, want);
	endtask

	function automatic int clamp_dim(logic [CNT_W-1:0] c);
		if (c < 1) return 1;
		if (c > DIM) return DIM;
		return int'(c);
	endfunction

	task automatic predict_products();
		int nr, nc, nk;
		longint acc;
		product_t p;
		nr = clamp_dim(a_rows);
		nk = clamp_dim(a_cols);
		nc = trans_b ? clamp_dim(b_rows) : clamp_dim(b_cols);
		for (int i = 0; i < nr; i++) begin
			for (int j = 0; j < nc; j++) begin
				acc = 0;
				for (int k = 0; k < nk; k++)
					acc += longint'(mat_a[i*DIM+k]) *
						longint'(trans_b ? mat_b[j*DIM+k] : mat_b[k*DIM+j]);
				p.row = IDX_W'(i);
				p.col = IDX_W'(j);
				p.value = acc[SUM_W-1:0];
				p.last = (i == nr-1) && (j == nc-1);
				pending_products.insert(pending_products.size(), p);
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 19);
		if (r < 12) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// caller is at a rising edge
	task automatic send_item(logic [1:0] op, logic [2:0] row, logic [2:0] col,
			logic [15:0] val);
		int gap;
		bit ok;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {val, col, row, op};
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		case (op)
			OP_LOAD_A: begin
				mat_a[row*DIM+col] = val;
				loads_sent++;
			end
			OP_LOAD_B: begin
				mat_b[row*DIM+col] = val;
				loads_sent++;
			end
			OP_COMPUTE: begin
				predict_products();
				computes_sent++;
			end
			default: ;
		endcase
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_products.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [3:0] val);
		bit ok;
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
		case (idx)
			REG_A_ROWS:  a_rows = val;
			REG_A_COLS:  a_cols = val;
			REG_B_ROWS:  b_rows = val;
			REG_B_COLS:  b_cols = val;
			REG_TRANS_B: trans_b = val[0];
			default: ;
		endcase
	endtask

	task automatic set_shape(logic [3:0] ar, logic [3:0] ac, logic [3:0] br,
			logic [3:0] bc, logic [3:0] tr);
		drain();
		write_reg(REG_A_ROWS, ar);
		write_reg(REG_A_COLS, ac);
		write_reg(REG_B_ROWS, br);
		write_reg(REG_B_COLS, bc);
		write_reg(REG_TRANS_B, tr);
	endtask

	task automatic load_random(logic [1:0] op);
		send_item(op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 16'($urandom()));
	endtask

	task automatic test_fill_stores();
		for (int r = 0; r < DIM; r++)
			for (int c = 0; c < DIM; c++) begin
				send_item(OP_LOAD_A, 3'(r), 3'(c), 16'($urandom()));
				send_item(OP_LOAD_B, 3'(r), 3'(c), 16'($urandom()));
			end
	endtask

	task automatic test_directed();
		send_item(OP_LOAD_A, 0, 0, 16'h8000);
		send_item(OP_LOAD_B, 0, 0, 16'h8000);
		send_item(OP_LOAD_A, 7, 7, 16'h7fff);
		send_item(OP_LOAD_B, 7, 7, 16'h7fff);
		send_item(OP_LOAD_A, 7, 0, 16'h0000);
		send_item(OP_LOAD_B, 0, 7, 16'hffff);
		send_item(OP_NONE, 7, 7, 16'hffff);
		send_item(OP_COMPUTE, 0, 0, 16'h0000);
		set_shape(8, 8, 8, 8, 4'hf);
		send_item(OP_COMPUTE, 7, 7, 16'hffff);
		set_shape(4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
		send_item(OP_COMPUTE, 0, 0, 16'h0000);
		set_shape(4'hf, 4'hf, 4'hf, 4'hf, 4'd1);
		send_item(OP_COMPUTE, 0, 0, 16'h0000);
		drain();
		write_reg(REG_UNUSED, 4'hf);
		send_item(OP_COMPUTE, 0, 0, 16'h0000);
	endtask

	task automatic test_random_mix();
		int r;
		for (int phase = 0; phase < 8; phase++) begin
			if (phase[0])
				set_shape(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					4'($urandom()));
			else
				set_shape(4'($urandom_range(1, 4)), 4'($urandom_range(1, 4)),
					4'($urandom_range(1, 4)), 4'($urandom_range(1, 4)),
					4'($urandom()));
			quiet = (phase == 3);
			for (int n = 0; n < 11; n++) begin
				r = $urandom_range(0, 19);
				if (r < 7) load_random(OP_LOAD_A);
				else if (r < 14) load_random(OP_LOAD_B);
				else if (r < 15)
					send_item(OP_NONE, 3'($urandom()), 3'($urandom()), 16'($urandom()));
				else
					send_item(OP_COMPUTE, 3'($urandom()), 3'($urandom()), 16'($urandom()));
			end
			quiet = 0;
		end
	endtask

	task automatic test_backpressure();
		set_shape(2, 3, 2, 2, 0);
		hold_cycles = 300;
		for (int n = 0; n < 8; n++)
			send_item(OP_COMPUTE, 0, 0, 16'h0000);
		drain();
		send_item(OP_COMPUTE, 0, 0, 16'h0000);
		drain();
	endtask

	// receiver
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else if (rx_stall > 0) begin
				m_tready <= 1'b0;
				rx_stall--;
			end else begin
				m_tready <= 1'b1;
				rx_stall = pick_gap();
			end
		end
	end

	// product checker, sampled away from the active edge
	always @(negedge clk) begin
		product_t want;
		if (arst_n && m_tvalid && m_tready) begin
			products_seen++;
			if (pending_products.size() == 0) begin
				report("unexpected product", m_tdata, 0);
			end else begin
				want = pending_products.pop_front();
				if (m_tdata[2:0] != want.row) report("row", m_tdata[2:0], want.row);
				if (m_tdata[5:3] != want.col) report("col", m_tdata[5:3], want.col);
				if (m_tdata[45:6] != want.value)
					report("value", m_tdata[45:6], want.value);
				if (m_tlast != want.last) report("last", m_tlast, want.last);
			end
		end
	end

	// watchdog
	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= IDLE_MAX) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		a_rows = 8;
		a_cols = 8;
		b_rows = 8;
		b_cols = 8;
		trans_b = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_stores();
		test_directed();
		test_random_mix();
		test_backpressure();
		drain();
		if (pending_products.size() > 0) report("products missing", pending_products.size(), 0);
		$display("covered %0d loads and %0d computes, %0d products checked",
			loads_sent, computes_sent, products_seen);
		$display("shapes from 1x1 to 8x8 incl. clamped counts, plain and transposed B");
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/mmt_pkg.sv
hdl/mmt_cell.sv
hdl/matrix_multiply_opt_transpose_core.sv
tb/tb_top.sv
